// ----- rtl/core/pcbp_pkg.sv -----
// Shared types and constants for the prefix code bit packer.
// No dependencies; imported by the front, queue, back and top-level modules.
`default_nettype none

package pcbp_pkg;

  localparam int GROUP_BITS = 7;   // bits per emitted character
  localparam int CODE_W     = 24;  // width of the code field
  localparam int LEN_W      = 5;   // width of the code length field
  localparam int SYM_W      = 8;   // width of the symbol field
  localparam int REQ_W      = 2;
  localparam int PAD_W      = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // One queued command for the back end.
  typedef struct packed {
    logic             flush;
    logic [LEN_W-1:0] len;
    logic [CODE_W-1:0] code;
  } cmd_t;

  // Queue status seen by producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/pcbp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/pcbp_fifo.sv -----
// Short command queue between the front and back of the bit packer.
// Depends on pcbp_pkg (cmd_t, q_stat_t).
`default_nettype none

module pcbp_fifo
  import pcbp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output q_stat_t   stat_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcbp_front.sv -----
// Front end: accepts input transactions, keeps the code table, and queues flush
// and nonzero-length encode commands. Depends on pcbp_pkg and pcbp_ram.
`default_nettype none

module pcbp_front
  import pcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256,
  parameter int LEN_CAP      = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [REQ_W-1:0]  in_req_type_i,
  input  wire logic [SYM_W-1:0]  in_symbol_i,
  input  wire logic [LEN_W-1:0]  in_code_length_i,
  input  wire logic [CODE_W-1:0] in_code_bits_i,
  output logic                   push_o,
  output cmd_t                   push_data_o,
  input  wire q_stat_t           q_stat_i
);

  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int ENT_W = LEN_W + CODE_W;
  localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(LEN_CAP);

  logic [SYMBOL_COUNT-1:0] loaded_q;
  logic                    s1_valid_q, s1_flush_q, s1_hit_q;
  logic                    accept, in_range, is_load, is_encode, is_flush;
  logic [IDX_W-1:0]        sym_idx;
  logic [LEN_W-1:0]        len_sat, rd_len;
  logic [ENT_W-1:0]        rd_entry;
  logic                    need_push, s1_free;

  assign sym_idx   = in_symbol_i[IDX_W-1:0];
  assign in_range  = ({1'b0, in_symbol_i} < SYM_LIMIT);
  assign is_load   = (in_req_type_i == REQ_LOAD);
  assign is_encode = (in_req_type_i == REQ_ENCODE);
  assign is_flush  = (in_req_type_i == REQ_FLUSH);
  assign len_sat   = (in_code_length_i > LEN_MAX) ? LEN_MAX : in_code_length_i;

  // Stage 1 holds the item while the table read returns.
  assign rd_len    = s1_hit_q ? rd_entry[ENT_W-1:CODE_W] : '0;
  assign need_push = s1_valid_q && (s1_flush_q || (rd_len != '0));
  assign s1_free   = !s1_valid_q || !(need_push && q_stat_i.full);
  assign in_stall_o = !s1_free;
  assign accept    = in_valid_i && s1_free;

  assign push_o            = need_push && !q_stat_i.full;
  assign push_data_o.flush = s1_flush_q;
  assign push_data_o.len   = rd_len;
  assign push_data_o.code  = rd_entry[CODE_W-1:0];

  pcbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && is_load && in_range),
    .waddr_i (sym_idx),
    .wdata_i ({len_sat, in_code_bits_i}),
    .re_i    (accept && is_encode && in_range),
    .raddr_i (sym_idx),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q   <= '0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      if (accept && is_load && in_range) begin
        loaded_q[sym_idx] <= 1'b1;
      end
      if (accept && (is_encode || is_flush)) begin
        s1_valid_q <= 1'b1;
        s1_flush_q <= is_flush;
        s1_hit_q   <= is_encode && in_range && loaded_q[sym_idx];
      end else if (s1_free) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcbp_back.sv -----
// Back end: merges queued codes into the bit accumulator and emits 7-bit
// groups and flush results through an output register. Depends on pcbp_pkg.
`default_nettype none

module pcbp_back
  import pcbp_pkg::*;
#(
  parameter int LEN_CAP = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  input  wire q_stat_t           q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [GROUP_BITS-1:0]  out_char_o,
  output logic                   out_char_valid_o,
  output logic [PAD_W-1:0]       out_pad_bits_o,
  output logic                   out_is_flush_o,
  output logic                   out_last_o
);

  localparam int ACC_W = GROUP_BITS - 1 + LEN_CAP;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam logic [CNT_W-1:0] GRP = CNT_W'(GROUP_BITS);

  // Bits gathered so far sit right aligned in acc_q, earliest highest;
  // anything above cnt_q is stale and never read.
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [GROUP_BITS-1:0] char_q, char_d;
  logic                  cvalid_q, cvalid_d;
  logic [PAD_W-1:0]      pad_q, pad_d;
  logic                  flush_q, flush_d;
  logic                  last_q, last_d;
  logic                  out_free, have_group;
  logic [CNT_W-1:0]      rest, pad_cnt;
  logic [CODE_W-1:0]     code_mask;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign have_group = (cnt_q >= GRP);
  assign rest       = cnt_q - GRP;
  assign pad_cnt    = GRP - cnt_q;
  assign code_mask  = ~({CODE_W{1'b1}} << cmd_i.len);
  assign pop_o      = !q_stat_i.empty && !have_group && (!cmd_i.flush || out_free);

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    cvalid_d    = cvalid_q;
    pad_d       = pad_q;
    flush_d     = flush_q;
    last_d      = last_q;
    if (have_group) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        char_d      = GROUP_BITS'(acc_q >> rest);
        cvalid_d    = 1'b1;
        pad_d       = '0;
        flush_d     = 1'b0;
        last_d      = (rest < GRP);
        cnt_d       = rest;
      end
    end else if (pop_o) begin
      if (cmd_i.flush) begin
        out_valid_d = 1'b1;
        char_d      = GROUP_BITS'(acc_q << pad_cnt);
        cvalid_d    = (cnt_q != '0);
        pad_d       = (cnt_q != '0) ? PAD_W'(pad_cnt) : '0;
        flush_d     = 1'b1;
        last_d      = 1'b1;
        cnt_d       = '0;
      end else begin
        acc_d = (acc_q << cmd_i.len) | ACC_W'(cmd_i.code & code_mask);
        cnt_d = cnt_q + CNT_W'(cmd_i.len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    char_q   <= char_d;
    cvalid_q <= cvalid_d;
    pad_q    <= pad_d;
    flush_q  <= flush_d;
    last_q   <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = char_q;
  assign out_char_valid_o = cvalid_q;
  assign out_pad_bits_o   = pad_q;
  assign out_is_flush_o   = flush_q;
  assign out_last_o       = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/prefix_code_bit_packer.sv -----
// Prefix code bit packer: loads a per-symbol code table, packs encoded symbols
// into 7-bit characters (earliest bit in the MSB) and pads on flush. An encode
// or flush transaction reads the code table in the front stage, then passes
// through a two-entry queue to the back end, which merges a code into the bit
// accumulator and then emits its characters, up to four per encode; a flush
// emits a single result. The back-end accumulator, which emits one character
// per cycle unless the output stalls, sets the sustained rate.
// Code lengths come up cleared after reset with no sweep: a per-symbol loaded
// flag marks written table entries.
`default_nettype none

module prefix_code_bit_packer
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 24,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [REQ_W-1:0]      in_req_type_i,
  input  wire logic [SYM_W-1:0]      in_symbol_i,
  input  wire logic [LEN_W-1:0]      in_code_length_i,
  input  wire logic [CODE_W-1:0]     in_code_bits_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [GROUP_BITS-1:0]      out_char_o,
  output logic                       out_char_valid_o,
  output logic [PAD_W-1:0]           out_pad_bits_o,
  output logic                       out_is_flush_o,
  output logic                       out_last_o
);

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic    push, pop;
  cmd_t    push_cmd, pop_cmd;
  q_stat_t q_stat;

  pcbp_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .LEN_CAP      (LEN_CAP)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_req_type_i    (in_req_type_i),
    .in_symbol_i      (in_symbol_i),
    .in_code_length_i (in_code_length_i),
    .in_code_bits_i   (in_code_bits_i),
    .push_o           (push),
    .push_data_o      (push_cmd),
    .q_stat_i         (q_stat)
  );

  pcbp_fifo #(
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .stat_o      (q_stat)
  );

  pcbp_back #(
    .LEN_CAP (LEN_CAP)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (pop_cmd),
    .q_stat_i         (q_stat),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .out_char_valid_o (out_char_valid_o),
    .out_pad_bits_o   (out_pad_bits_o),
    .out_is_flush_o   (out_is_flush_o),
    .out_last_o       (out_last_o)
  );

endmodule

`default_nettype wire
